// ===== design/pcm8u_pkg.sv =====
// Shared constants, types and coefficient tables for the PCM8 polyphase upsampler.
// No dependencies; every other design file imports this package.

package pcm8u_pkg;

  localparam int NUM_TAPS     = 28;
  localparam int HIST_DEPTH   = NUM_TAPS / 2;
  localparam int QUARTER_P    = NUM_TAPS / 4;
  localparam int QUARTER_BASE = HIST_DEPTH - QUARTER_P;
  localparam int POS_W        = $clog2(HIST_DEPTH);
  localparam int IDX_W        = $clog2(NUM_TAPS + 4);
  localparam int ACC_W        = 36;

  typedef logic        [7:0]       pcm_t;
  typedef logic signed [15:0]      sample_t;
  typedef logic signed [15:0]      coef_t;
  typedef logic signed [31:0]      prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic        [2:0]       factor_t;
  typedef logic        [POS_W-1:0] pos_t;
  typedef logic        [IDX_W-1:0] idx_t;
  typedef logic        [1:0]       phase_t;

  localparam factor_t FACTOR_HALF  = 3'd2;
  localparam factor_t FACTOR_RESET = 3'd4;

  localparam acc_t SAT_MAX = 36'sd32767;
  localparam acc_t SAT_MIN = -36'sd32768;

  typedef struct packed {
    logic en;
    logic zero;
  } cell_ctrl_t;

  typedef struct packed {
    logic vld;
    logic first;
  } mac_ctrl_t;

  function automatic sample_t pcm_to_q15(input pcm_t pcm);
    return sample_t'({~pcm[7], pcm[6:0], 8'h00});
  endfunction

  function automatic coef_t coef_quarter(input idx_t idx);
    coef_t c;
    case (idx)
      5'd0, 5'd27:  c = -16'sd57;
      5'd1, 5'd26:  c = -16'sd29;
      5'd2, 5'd25:  c = 16'sd44;
      5'd3, 5'd24:  c = 16'sd172;
      5'd4, 5'd23:  c = 16'sd269;
      5'd5, 5'd22:  c = 16'sd167;
      5'd6, 5'd21:  c = -16'sd245;
      5'd7, 5'd20:  c = -16'sd841;
      5'd8, 5'd19:  c = -16'sd1178;
      5'd9, 5'd18:  c = -16'sd683;
      5'd10, 5'd17: c = 16'sd977;
      5'd11, 5'd16: c = 16'sd3567;
      5'd12, 5'd15: c = 16'sd6252;
      5'd13, 5'd14: c = 16'sd7966;
      default:      c = 16'sd0;
    endcase
    return c;
  endfunction

  function automatic coef_t coef_half(input idx_t idx);
    coef_t c;
    case (idx)
      5'd0, 5'd27:  c = 16'sd43;
      5'd1, 5'd26:  c = 16'sd54;
      5'd2, 5'd25:  c = -16'sd82;
      5'd3, 5'd24:  c = -16'sd131;
      5'd4, 5'd23:  c = 16'sd205;
      5'd5, 5'd22:  c = 16'sd309;
      5'd6, 5'd21:  c = -16'sd451;
      5'd7, 5'd20:  c = -16'sd641;
      5'd8, 5'd19:  c = 16'sd898;
      5'd9, 5'd18:  c = 16'sd1259;
      5'd10, 5'd17: c = -16'sd1798;
      5'd11, 5'd16: c = -16'sd2720;
      5'd12, 5'd15: c = 16'sd4769;
      5'd13, 5'd14: c = 16'sd14669;
      default:      c = 16'sd0;
    endcase
    return c;
  endfunction

  function automatic sample_t sat_q15(input acc_t acc);
    acc_t q;
    q = acc >>> 15;
    if (q > SAT_MAX) begin
      return 16'sh7fff;
    end else if (q < SAT_MIN) begin
      return -16'sh8000;
    end
    return sample_t'(q[15:0]);
  endfunction

endpackage

// ===== design/pcm8u_ifs.sv =====
// Valid/ready channel interfaces: sample requests in, results out, factor writes.
// Depends on pcm8u_pkg for payload types.

interface pcm8u_in_if;
  import pcm8u_pkg::*;
  logic valid;
  logic ready;
  pcm_t pcm_sample;
  logic first_sample;
  modport source (output valid, output pcm_sample, output first_sample, input ready);
  modport sink (input valid, input pcm_sample, input first_sample, output ready);
endinterface

interface pcm8u_out_if;
  import pcm8u_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;
  logic    last_of_run;
  modport source (output valid, output left_sample, output right_sample,
                  output last_of_run, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input last_of_run, output ready);
endinterface

interface pcm8u_cfg_if;
  import pcm8u_pkg::*;
  logic    valid;
  logic    ready;
  factor_t interp_factor;
  modport source (output valid, output interp_factor, input ready);
  modport sink (input valid, input interp_factor, output ready);
endinterface

// ===== design/pcm8u_cell.sv =====
// One history cell of the sample ring: loads its neighbor's value or zero.
// Depends on pcm8u_pkg.

module pcm8u_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcm8u_pkg::cell_ctrl_t  ctrl_i,
  input  pcm8u_pkg::sample_t     d_i,
  output pcm8u_pkg::sample_t     q_o
);
  import pcm8u_pkg::*;

  sample_t value_r;
  sample_t value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl_i.en) begin
      value_nxt = ctrl_i.zero ? sample_t'(0) : d_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign q_o = value_r;

endmodule

// ===== design/pcm8u_mac.sv =====
// Shared multiply-accumulate unit: registered product, then wide accumulator.
// Depends on pcm8u_pkg.

module pcm8u_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcm8u_pkg::mac_ctrl_t  ctrl_i,
  input  pcm8u_pkg::sample_t    sample_i,
  input  pcm8u_pkg::coef_t      coef_i,
  output pcm8u_pkg::acc_t       acc_o
);
  import pcm8u_pkg::*;

  prod_t     prod_r;
  prod_t     prod_nxt;
  mac_ctrl_t pctl_r;
  acc_t      acc_r;
  acc_t      acc_nxt;

  always_comb begin
    prod_nxt = sample_i * coef_i;
    acc_nxt  = acc_r;
    if (pctl_r.vld) begin
      acc_nxt = (pctl_r.first ? acc_t'(0) : acc_r) + acc_t'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pctl_r <= '0;
      acc_r  <= '0;
    end else begin
      pctl_r <= ctrl_i;
      acc_r  <= acc_nxt;
    end
    prod_r <= prod_nxt;
  end

  assign acc_o = acc_r;

endmodule

// ===== design/pcm8_polyphase_upsampler.sv =====
// Top level: 14-cell sample ring, shared MAC, phase sequencer and output register.
// Depends on pcm8u_pkg, pcm8u_ifs, pcm8u_cell and pcm8u_mac.
// Flow: a sample request is taken only in ST_IDLE, so a new one waits until every output
//   phase of the last is done; each phase rotates the ring once past the single MAC in
//   ST_RUN, drains in ST_DRAIN and loads the output register in ST_EMIT, which stalls
//   while the output register still holds an unaccepted result.
// Reset: history cleared to zero, factor set to 4, output register empty.

module pcm8_polyphase_upsampler (
  input  logic               clk,
  input  logic               rst_n,
  pcm8u_in_if.sink           in_if,
  pcm8u_out_if.source        out_if,
  pcm8u_cfg_if.sink          cfg_if
);
  import pcm8u_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} state_t;

  state_t  state_r, state_nxt;
  pos_t    pos_r, pos_nxt;
  phase_t  phase_r, phase_nxt;
  idx_t    idx_r, idx_nxt;
  factor_t factor_r, factor_nxt;
  logic    out_vld_r, out_vld_nxt;
  sample_t out_smp_r, out_smp_nxt;
  logic    out_last_r, out_last_nxt;

  sample_t    hist [HIST_DEPTH];
  cell_ctrl_t cell_ctrl [HIST_DEPTH];
  sample_t    cell_d [HIST_DEPTH];

  logic      push;
  logic      rotate;
  logic      half;
  phase_t    lf_m1;
  pos_t      base;
  idx_t      step;
  idx_t      coef_idx;
  coef_t     coef;
  mac_ctrl_t mac_ctrl;
  acc_t      acc;
  logic      out_free;

  assign push   = in_if.valid && in_if.ready;
  assign rotate = (state_r == ST_RUN);
  assign half   = (factor_r == FACTOR_HALF);
  assign lf_m1  = half ? 2'd1 : 2'd3;
  assign base   = half ? pos_t'(0) : pos_t'(QUARTER_BASE);
  assign step   = half ? idx_t'(2) : idx_t'(4);

  genvar gi;
  generate
    for (gi = 0; gi < HIST_DEPTH; gi++) begin : g_cell
      if (gi == HIST_DEPTH - 1) begin : g_head
        assign cell_d[gi]         = push ? pcm_to_q15(in_if.pcm_sample) : hist[0];
        assign cell_ctrl[gi].zero = 1'b0;
      end else begin : g_body
        assign cell_d[gi]         = hist[gi + 1];
        assign cell_ctrl[gi].zero = push && in_if.first_sample;
      end
      assign cell_ctrl[gi].en = push || rotate;
      pcm8u_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl_i (cell_ctrl[gi]),
        .d_i    (cell_d[gi]),
        .q_o    (hist[gi])
      );
    end
  endgenerate

  always_comb begin
    mac_ctrl.vld   = rotate && (pos_r >= base);
    mac_ctrl.first = (pos_r == base);
    coef_idx       = mac_ctrl.first ? idx_t'(lf_m1 - phase_r) : idx_r;
    coef           = half ? coef_half(coef_idx) : coef_quarter(coef_idx);
  end

  pcm8u_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (mac_ctrl),
    .sample_i (hist[0]),
    .coef_i   (coef),
    .acc_o    (acc)
  );

  assign out_free = !out_vld_r || out_if.ready;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    factor_nxt   = factor_r;
    out_vld_nxt  = out_vld_r && !out_if.ready;
    out_smp_nxt  = out_smp_r;
    out_last_nxt = out_last_r;
    if (cfg_if.valid) begin
      factor_nxt = cfg_if.interp_factor;
    end
    if (mac_ctrl.vld) begin
      idx_nxt = coef_idx + step;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (push) begin
          state_nxt = ST_RUN;
          pos_nxt   = '0;
          phase_nxt = '0;
        end
      end
      ST_RUN: begin
        if (pos_r == pos_t'(HIST_DEPTH - 1)) begin
          pos_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          pos_nxt = pos_r + pos_t'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_smp_nxt  = sat_q15(acc);
          out_last_nxt = (phase_r == lf_m1);
          if (phase_r == lf_m1) begin
            state_nxt = ST_IDLE;
          end else begin
            phase_nxt = phase_r + phase_t'(1);
            state_nxt = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      phase_r   <= '0;
      factor_r  <= FACTOR_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      factor_r  <= factor_nxt;
      out_vld_r <= out_vld_nxt;
    end
    idx_r      <= idx_nxt;
    out_smp_r  <= out_smp_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_if.ready         = (state_r == ST_IDLE);
  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_vld_r;
  assign out_if.left_sample  = out_smp_r;
  assign out_if.right_sample = out_smp_r;
  assign out_if.last_of_run  = out_last_r;

endmodule
